@@ rtl/morse_keyer_envelope_sequencer_defines.svh @@
// Assertion macros for the Morse keyer envelope sequencer.
`ifndef MORSE_KEYER_ENVELOPE_SEQUENCER_DEFINES_SVH
`define MORSE_KEYER_ENVELOPE_SEQUENCER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define MKES_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MKES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MKES_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define MKES_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/mkes_pkg.sv @@
// Types, constants and the raised-cosine taper table of the Morse keyer.
package mkes_pkg;

  localparam int unsigned RomSize = 100;
  localparam logic [14:0] FullScale = 15'h7FFF;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_UP,
    MODE_HOLD,
    MODE_DOWN,
    MODE_EGAP,
    MODE_CGAP
  } mode_e;

  typedef enum logic [1:0] {
    REG_DOT,
    REG_DASH,
    REG_EGAP,
    REG_CGAP
  } reg_idx_e;

  localparam logic [14:0] TaperRom [RomSize] = '{
    15'h0000, 15'h0008, 15'h0020, 15'h004A, 15'h0083, 15'h00CD, 15'h0128, 15'h0192,
    15'h020D, 15'h0297, 15'h0332, 15'h03DC, 15'h0495, 15'h055E, 15'h0636, 15'h071D,
    15'h0812, 15'h0916, 15'h0A28, 15'h0B48, 15'h0C76, 15'h0DB1, 15'h0EF9, 15'h104D,
    15'h11AE, 15'h131A, 15'h1493, 15'h1616, 15'h17A4, 15'h193D, 15'h1AE0, 15'h1C8C,
    15'h1E41, 15'h1FFF, 15'h21C6, 15'h2394, 15'h2569, 15'h2745, 15'h2928, 15'h2B10,
    15'h2CFE, 15'h2EF1, 15'h30E8, 15'h32E4, 15'h34E2, 15'h36E3, 15'h38E7, 15'h3AED,
    15'h3CF3, 15'h3EFB, 15'h4103, 15'h430B, 15'h4511, 15'h4717, 15'h491B, 15'h4B1C,
    15'h4D1A, 15'h4F16, 15'h510D, 15'h5300, 15'h54EE, 15'h56D6, 15'h58B9, 15'h5A95,
    15'h5C6A, 15'h5E38, 15'h5FFF, 15'h61BD, 15'h6372, 15'h651E, 15'h66C1, 15'h685A,
    15'h69E8, 15'h6B6B, 15'h6CE4, 15'h6E50, 15'h6FB1, 15'h7105, 15'h724D, 15'h7388,
    15'h74B6, 15'h75D6, 15'h76E8, 15'h77EC, 15'h78E1, 15'h79C8, 15'h7AA0, 15'h7B69,
    15'h7C22, 15'h7CCC, 15'h7D67, 15'h7DF1, 15'h7E6C, 15'h7ED6, 15'h7F31, 15'h7F7B,
    15'h7FB4, 15'h7FDE, 15'h7FF6, 15'h7FFF
  };

  // Indexes past the end of the table read as full scale.
  function automatic logic [14:0] taper_read(input logic [8:0] idx);
    logic [14:0] val;
    val = FullScale;
    if (idx < 9'(RomSize)) begin
      val = TaperRom[idx[6:0]];
    end
    return val;
  endfunction

endpackage

@@ rtl/morse_keyer_envelope_sequencer.sv @@
// Top level of the Morse keyer envelope sequencer.
`include "morse_keyer_envelope_sequencer_defines.svh"

// One beat per sample tick or character start. The block takes one input beat every clock
// cycle while the output is empty or being taken, and presents its result in the next
// cycle; the taper table read is registered straight into the output register. A start
// beat latches a marker-coded character and a phase increment; each following tick beat
// returns the envelope, oscillator enable, phase increment, busy flag and a last-tick
// mark. Starts while busy or with code 0 or 1 come back with rejected set. Timing
// registers are written through the APB port at byte addresses 0, 4, 8 and 12 and apply
// the next time a length is loaded. No clearing pass runs after reset.
module morse_keyer_envelope_sequencer #(
  parameter int unsigned TAPER_LEN = 100
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [7:0]  code_byte_i,
  input  logic [15:0] phase_step_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [14:0] envelope_o,
  output logic        osc_enable_o,
  output logic [15:0] phase_out_o,
  output logic        busy_res_o,
  output logic        char_last_o,
  output logic        rejected_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mkes_pkg::*;

  localparam int unsigned RW = $clog2(TAPER_LEN + 1);
  localparam logic [RW-1:0] TaperEnd = RW'(TAPER_LEN);
  localparam logic [RW-1:0] TaperLast = RW'(TAPER_LEN - 1);

  logic [15:0] dot_q, dash_q, egap_q, cgap_q;
  mode_e       mode_q, mode_d;
  logic [RW-1:0] ramp_q, ramp_d;
  logic [15:0] tick_q, tick_d;
  logic [7:0]  mask_q, mask_d;
  logic [7:0]  code_q, code_d;
  logic [15:0] phase_q, phase_d;

  logic        out_valid_q;
  logic [14:0] env_q;
  logic        osc_q, busy_q, last_q, rej_q;
  logic [15:0] phase_out_q;

  logic        in_fire, cfg_write;
  logic        env_en, osc, busy, last, rej;
  logic [RW-1:0] rom_addr, ramp_dec;
  logic [7:0]  marker, ne_mask;
  mode_e       ne_mode;
  logic [15:0] tick_dec;

  assign in_fire   = in_valid_i && in_ready_o;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_comb begin
    prdata = '0;
    case (reg_idx_e'(paddr[3:2]))
      REG_DOT:  prdata = {16'b0, dot_q};
      REG_DASH: prdata = {16'b0, dash_q};
      REG_EGAP: prdata = {16'b0, egap_q};
      REG_CGAP: prdata = {16'b0, cgap_q};
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q  <= 16'd400;
      dash_q <= 16'd1200;
      egap_q <= 16'd400;
      cgap_q <= 16'd800;
    end else if (cfg_write) begin
      case (reg_idx_e'(paddr[3:2]))
        REG_DOT:  dot_q  <= pwdata[15:0];
        REG_DASH: dash_q <= pwdata[15:0];
        REG_EGAP: egap_q <= pwdata[15:0];
        REG_CGAP: cgap_q <= pwdata[15:0];
        default:  dot_q  <= dot_q;
      endcase
    end
  end

  always_comb begin
    marker = '0;
    for (int i = 0; i < 8; i++) begin
      if (code_byte_i[i]) begin
        marker = 8'(1 << i);
      end
    end
  end

  always_comb begin
    ne_mask = {1'b0, mask_q[7:1]};
    if (ne_mask != '0) begin
      ne_mode = MODE_UP;
    end else if (cgap_q != '0) begin
      ne_mode = MODE_CGAP;
    end else begin
      ne_mode = MODE_IDLE;
    end
  end

  assign tick_dec = tick_q - 16'd1;
  assign ramp_dec = (ramp_q != '0) ? ramp_q - RW'(1) : ramp_q;

  always_comb begin
    mode_d   = mode_q;
    ramp_d   = ramp_q;
    tick_d   = tick_q;
    mask_d   = mask_q;
    code_d   = code_q;
    phase_d  = phase_q;
    rom_addr = ramp_q;
    env_en   = 1'b0;
    osc      = 1'b0;
    busy     = 1'b0;
    last     = 1'b0;
    rej      = 1'b0;
    if (opcode_i) begin
      if (mode_q != MODE_IDLE || code_byte_i[7:1] == '0) begin
        rej = 1'b1;
      end else begin
        code_d  = code_byte_i;
        mask_d  = {1'b0, marker[7:1]};
        phase_d = phase_step_i;
        mode_d  = MODE_UP;
        ramp_d  = '0;
        tick_d  = '0;
      end
      busy = (mode_d != MODE_IDLE);
    end else if (mode_q != MODE_IDLE) begin
      busy = 1'b1;
      case (mode_q)
        MODE_UP: begin
          env_en = 1'b1;
          osc    = 1'b1;
          ramp_d = ramp_q + RW'(1);
          if (ramp_q >= TaperLast) begin
            ramp_d = TaperEnd;
            mode_d = MODE_HOLD;
            tick_d = ((code_q & mask_q) != '0) ? dash_q : dot_q;
          end
        end
        MODE_HOLD: begin
          rom_addr = TaperLast;
          env_en   = 1'b1;
          osc      = 1'b1;
          tick_d   = tick_dec;
          if (tick_dec == '0) begin
            mode_d = MODE_DOWN;
          end
        end
        MODE_DOWN: begin
          ramp_d   = ramp_dec;
          rom_addr = ramp_dec;
          env_en   = 1'b1;
          osc      = 1'b1;
          if (ramp_dec == '0) begin
            if (egap_q != '0) begin
              mode_d = MODE_EGAP;
              tick_d = egap_q;
            end else begin
              mask_d = ne_mask;
              mode_d = ne_mode;
              ramp_d = '0;
              tick_d = (ne_mode == MODE_CGAP) ? cgap_q : tick_q;
            end
          end
        end
        MODE_EGAP: begin
          tick_d = tick_dec;
          if (tick_dec == '0) begin
            mask_d = ne_mask;
            mode_d = ne_mode;
            ramp_d = '0;
            tick_d = (ne_mode == MODE_CGAP) ? cgap_q : tick_dec;
          end
        end
        default: begin
          tick_d = tick_dec;
          if (tick_dec == '0) begin
            mode_d = MODE_IDLE;
          end
        end
      endcase
      last = (mode_d == MODE_IDLE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      ramp_q  <= '0;
      tick_q  <= '0;
      mask_q  <= '0;
      code_q  <= '0;
      phase_q <= '0;
    end else if (in_fire) begin
      mode_q  <= mode_d;
      ramp_q  <= ramp_d;
      tick_q  <= tick_d;
      mask_q  <= mask_d;
      code_q  <= code_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      env_q       <= env_en ? taper_read(9'(rom_addr)) : '0;
      osc_q       <= osc;
      busy_q      <= busy;
      last_q      <= last;
      rej_q       <= rej;
      phase_out_q <= phase_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign envelope_o   = env_q;
  assign osc_enable_o = osc_q;
  assign phase_out_o  = phase_out_q;
  assign busy_res_o   = busy_q;
  assign char_last_o  = last_q;
  assign rejected_o   = rej_q;

  `MKES_ASSERT_IMPLY(a_osc_busy, clk_i, rst_ni, out_valid_o && osc_enable_o, busy_res_o)
  `MKES_ASSERT_IMPLY(a_rej_quiet, clk_i, rst_ni, out_valid_o && rejected_o,
                     !osc_enable_o && !char_last_o && envelope_o == '0)
  `MKES_ASSERT_IMPLY(a_hold_ramp, clk_i, rst_ni, mode_q == MODE_HOLD, ramp_q == TaperEnd)
  `MKES_ASSERT_NEXT(a_start_up, clk_i, rst_ni,
                    in_fire && opcode_i && mode_q == MODE_IDLE && code_byte_i[7:1] != '0,
                    mode_q == MODE_UP && out_valid_o && busy_res_o && !rejected_o)

endmodule
